// File: sv/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit.
// Holds the command codes, relation codes and the transaction payload structs.
// No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int IN_W  = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_NEG = 3'd4,
        CMD_CMP = 3'd5
    } t_cmd;

    localparam logic [1:0] REL_EQ = 2'd0;
    localparam logic [1:0] REL_LT = 2'd1;
    localparam logic [1:0] REL_GT = 2'd2;

    typedef struct packed {
        logic [2:0]             command;
        logic signed [IN_W-1:0] num_a;
        logic signed [IN_W-1:0] den_a;
        logic signed [IN_W-1:0] num_b;
        logic signed [IN_W-1:0] den_b;
    } t_in_item;

    typedef struct packed {
        logic signed [NUM_W-1:0] num_out;
        logic [DEN_W-1:0]        den_out;
        logic [1:0]              relation;
        logic                    error;
    } t_out_item;

endpackage

// File: sv/rau_front.sv
// rau_front: accepts transactions, normalizes signs, forms the cross-products
// with one shared multiplier and classifies the command. Uses rau_pkg.
`timescale 1ns / 1ps

module rau_front #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rau_pkg::t_in_item   i_data,
    output logic                o_push,
    output logic [4*W+3:0]      o_entry,
    input  logic                i_full
);
    import rau_pkg::*;

    localparam int U  = 2 * W;
    localparam int PW = 2 * W + 2;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    typedef struct packed {
        logic         neg;
        logic [U-1:0] mag;
        logic [U-1:0] den;
        logic [1:0]   rel;
        logic         err;
    } t_entry;

    t_fstate r_state, n_state;
    logic [1:0] r_step;
    logic [2:0] r_cmd;
    logic signed [W:0] r_pa, r_qa, r_pb, r_qb;
    logic signed [PW-1:0] r_l, r_r, r_qq, r_pp;

    logic [IN_W+W-1:0] ext_pa, ext_qa, ext_pb, ext_qb;
    logic signed [W:0] s_pa, s_qa, s_pb, s_qb;
    logic signed [W:0] mx, my;
    logic signed [PW-1:0] prod;
    logic qa_z, qb_z, pb_z, err, done;
    logic [1:0] rel;
    logic signed [PW-1:0] n, d;
    logic signed [PW-1:0] mag_full;
    t_entry entry;

    assign ext_pa = {{W{1'b0}}, i_data.num_a};
    assign ext_qa = {{W{1'b0}}, i_data.den_a};
    assign ext_pb = {{W{1'b0}}, i_data.num_b};
    assign ext_qb = {{W{1'b0}}, i_data.den_b};

    always_comb begin
        s_pa = {ext_pa[W-1], ext_pa[W-1:0]};
        s_qa = {ext_qa[W-1], ext_qa[W-1:0]};
        s_pb = {ext_pb[W-1], ext_pb[W-1:0]};
        s_qb = {ext_qb[W-1], ext_qb[W-1:0]};
        if (s_qa < 0) begin
            s_qa = -s_qa;
            s_pa = -s_pa;
        end
        if (s_qb < 0) begin
            s_qb = -s_qb;
            s_pb = -s_pb;
        end
    end

    always_comb begin
        case (r_step)
            2'd0:    begin mx = r_pa; my = r_qb; end
            2'd1:    begin mx = r_pb; my = r_qa; end
            2'd2:    begin mx = r_qa; my = r_qb; end
            default: begin mx = r_pa; my = r_pb; end
        endcase
        prod = PW'(mx * my);
    end

    always_comb begin
        qa_z = (r_qa == '0);
        qb_z = (r_qb == '0);
        pb_z = (r_pb == '0);
        if (!qa_z && !qb_z) begin
            rel = (r_l == r_r) ? REL_EQ : ((r_l < r_r) ? REL_LT : REL_GT);
        end else begin
            rel = REL_EQ;
        end
        err  = 1'b0;
        done = 1'b1;
        n    = r_l + r_r;
        d    = r_qq;
        case (r_cmd)
            CMD_ADD: begin
                err = qa_z | qb_z;
            end
            CMD_SUB: begin
                err = qa_z | qb_z;
                n   = r_l - r_r;
            end
            CMD_MUL: begin
                err = qa_z | qb_z;
                n   = r_pp;
            end
            CMD_DIV: begin
                err = qa_z | qb_z | pb_z;
                n   = r_l;
                d   = r_r;
                if (r_r < 0) begin
                    n = -r_l;
                    d = -r_r;
                end
            end
            CMD_NEG: begin
                err = qa_z;
                n   = -PW'(r_pa);
                d   = PW'(r_qa);
            end
            CMD_CMP: begin
                err  = qa_z | qb_z;
                done = 1'b0;
            end
            default: begin
                err  = 1'b1;
                done = 1'b0;
            end
        endcase
        if (err || !done) begin
            n = '0;
            d = PW'(1);
        end
        mag_full  = (n < 0) ? -n : n;
        entry.neg = (n < 0);
        entry.mag = mag_full[U-1:0];
        entry.den = d[U-1:0];
        entry.rel = rel;
        entry.err = err;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_entry = entry;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_MUL;
            F_MUL:   if (r_step == 2'd3) n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_pa   <= s_pa;
            r_qa   <= s_qa;
            r_pb   <= s_pb;
            r_qb   <= s_qb;
            r_cmd  <= i_data.command;
            r_step <= 2'd0;
        end else if (r_state == F_MUL) begin
            r_step <= r_step + 2'd1;
            case (r_step)
                2'd0:    r_l  <= prod;
                2'd1:    r_r  <= prod;
                2'd2:    r_qq <= prod;
                default: r_pp <= prod;
            endcase
        end
    end

endmodule

// File: sv/rau_queue.sv
// rau_queue: two-entry queue between the front and back parts.
// Generic payload vector; no dependencies.
`timescale 1ns / 1ps

module rau_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);
    logic [DW-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: sv/rau_back.sv
// rau_back: reduces each queued fraction by binary GCD and two restoring
// divisions on one shared divider, then holds the result. Uses rau_pkg.
`timescale 1ns / 1ps

module rau_back #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_pop,
    input  logic [4*W+3:0]      i_entry,
    output logic                o_valid,
    input  logic                i_ready,
    output rau_pkg::t_out_item  o_data
);
    import rau_pkg::*;

    localparam int U   = 2 * W;
    localparam int KW  = $clog2(U + 1);
    localparam int CW  = $clog2(U);
    localparam int XW  = (U + 1 > NUM_W) ? U + 1 : NUM_W;
    localparam int DXW = (U > DEN_W) ? U : DEN_W;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_TZ   = 6'b000010,
        B_GCD  = 6'b000100,
        B_DIVN = 6'b001000,
        B_DIVD = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    typedef struct packed {
        logic         neg;
        logic [U-1:0] mag;
        logic [U-1:0] den;
        logic [1:0]   rel;
        logic         err;
    } t_entry;

    t_bstate r_state;
    t_entry entry;
    logic [U-1:0] r_a, r_b, r_g, r_mag, r_den, r_nq, r_quo, r_rem;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    logic r_neg, r_err;
    logic [1:0] r_rel;
    logic r_ovalid;
    t_out_item r_out;

    logic [U:0] rem_sh, diff;
    logic [U-1:0] quo_nx, rem_nx;
    logic [XW-1:0] nz, nv;
    logic [DXW-1:0] dz;
    logic load_out;

    assign entry = i_entry;
    assign o_pop = (r_state == B_IDLE) && i_valid;
    assign load_out = (r_state == B_OUT) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        rem_sh = {r_rem, r_quo[U-1]};
        diff   = rem_sh - {1'b0, r_g};
        quo_nx = {r_quo[U-2:0], ~diff[U]};
        rem_nx = diff[U] ? rem_sh[U-1:0] : diff[U-1:0];
        nz     = XW'(r_nq);
        nv     = r_neg ? -nz : nz;
        dz     = DXW'(r_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: if (i_valid) r_state <= B_TZ;
                B_TZ:   if (r_a[0] || r_b[0]) r_state <= B_GCD;
                B_GCD:  if (r_a == '0) r_state <= B_DIVN;
                B_DIVN: if (r_cnt == '0) r_state <= B_DIVD;
                B_DIVD: if (r_cnt == '0) r_state <= B_OUT;
                B_OUT:  if (load_out) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_a   <= entry.mag;
                r_b   <= entry.den;
                r_mag <= entry.mag;
                r_den <= entry.den;
                r_neg <= entry.neg;
                r_rel <= entry.rel;
                r_err <= entry.err;
                r_k   <= '0;
            end
            B_TZ: begin
                if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + KW'(1);
                end
            end
            B_GCD: begin
                if (r_a == '0) begin
                    r_g   <= r_b << r_k;
                    r_quo <= r_mag;
                    r_rem <= '0;
                    r_cnt <= CW'(U - 1);
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= (r_a - r_b) >> 1;
                end else begin
                    r_b <= (r_b - r_a) >> 1;
                end
            end
            B_DIVN: begin
                if (r_cnt == '0) begin
                    r_nq  <= quo_nx;
                    r_quo <= r_den;
                    r_rem <= '0;
                    r_cnt <= CW'(U - 1);
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                    r_quo <= quo_nx;
                    r_rem <= rem_nx;
                end
            end
            B_DIVD: begin
                r_cnt <= r_cnt - CW'(1);
                r_quo <= quo_nx;
                r_rem <= rem_nx;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (load_out) begin
            r_out.num_out  <= nv[NUM_W-1:0];
            r_out.den_out  <= dz[DEN_W-1:0];
            r_out.relation <= r_rel;
            r_out.error    <= r_err;
        end
    end

endmodule

// File: sv/rational_arithmetic_unit.sv
// rational_arithmetic_unit: exact fraction arithmetic with GCD reduction.
// Front: one shared multiplier forms four products per transaction.
// Back: per transaction, a binary GCD loop and two 2*OPERAND_WIDTH-step
// restoring divisions. A two-entry queue decouples both.
// Synchronous active-low reset clears control state, queue and output valid.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rau_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rau_pkg::t_out_item  o_data
);
    import rau_pkg::*;

    localparam int EW = 4 * OPERAND_WIDTH + 4;

    logic q_push, q_full, q_valid, q_pop;
    logic [EW-1:0] q_in, q_out;

    rau_front #(.W(OPERAND_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (q_push),
        .o_entry (q_in),
        .i_full  (q_full)
    );

    rau_queue #(.DW(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    rau_back #(.W(OPERAND_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_entry (q_out),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error |-> o_data.num_out == '0 && o_data.den_out == DEN_W'(1))
        else $error("error result not 0/1");

    a_rel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.relation != 2'd3)
        else $error("bad relation code");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// File: bench/tb_top.sv
// tb_top: testbench for rational_arithmetic_unit with a fraction-arithmetic scoreboard.
// Drives random and directed fraction pairs over valid/ready and checks each result.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 1ps

module tb_top;
    import rau_pkg::*;

    class fraction_scoreboard;
        t_out_item pending[$];
        int        n_errors;

        function new();
            n_errors = 0;
        endfunction

        function automatic longint unsigned gcd(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function automatic t_out_item predict(t_in_item it);
            t_out_item       r;
            longint          pa, qa, pb, qb, n, d, l, rr;
            longint unsigned mag, g;
            logic            ok;
            pa = longint'(it.num_a);
            qa = longint'(it.den_a);
            pb = longint'(it.num_b);
            qb = longint'(it.den_b);
            n = 0;
            d = 1;
            ok = 0;
            r.relation = REL_EQ;
            r.error = 0;
            if (qa < 0) begin
                qa = -qa;
                pa = -pa;
            end
            if (qb < 0) begin
                qb = -qb;
                pb = -pb;
            end
            if (qa != 0 && qb != 0) begin
                l = pa * qb;
                rr = pb * qa;
                r.relation = (l == rr) ? REL_EQ : ((l < rr) ? REL_LT : REL_GT);
            end
            case (it.command)
                CMD_ADD, CMD_SUB: begin
                    if (qa == 0 || qb == 0) begin
                        r.error = 1;
                    end else begin
                        n = (it.command == CMD_ADD) ? pa * qb + pb * qa : pa * qb - pb * qa;
                        d = qa * qb;
                        ok = 1;
                    end
                end
                CMD_MUL: begin
                    if (qa == 0 || qb == 0) begin
                        r.error = 1;
                    end else begin
                        n = pa * pb;
                        d = qa * qb;
                        ok = 1;
                    end
                end
                CMD_DIV: begin
                    if (qa == 0 || qb == 0 || pb == 0) begin
                        r.error = 1;
                    end else begin
                        n = pa * qb;
                        d = qa * pb;
                        if (d < 0) begin
                            d = -d;
                            n = -n;
                        end
                        ok = 1;
                    end
                end
                CMD_NEG: begin
                    if (qa == 0) begin
                        r.error = 1;
                    end else begin
                        n = -pa;
                        d = qa;
                        ok = 1;
                    end
                end
                CMD_CMP: begin
                    if (qa == 0 || qb == 0) r.error = 1;
                end
                default: r.error = 1;
            endcase
            if (ok) begin
                mag = (n < 0) ? longint'(-n) : longint'(n);
                g = gcd(mag, longint'(d));
                mag = mag / g;
                d = d / longint'(g);
                n = (n < 0) ? -longint'(mag) : longint'(mag);
            end else begin
                n = 0;
                d = 1;
            end
            r.num_out = n[NUM_W-1:0];
            r.den_out = d[DEN_W-1:0];
            return r;
        endfunction

        function void note_input(t_in_item it);
            pending.push_back(predict(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $error("unexpected result num=%0d den=%0d", got.num_out, got.den_out);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got.num_out !== want.num_out) begin
                $error("num_out expected %0d actual %0d", want.num_out, got.num_out);
                n_errors++;
            end
            if (got.den_out !== want.den_out) begin
                $error("den_out expected %0d actual %0d", want.den_out, got.den_out);
                n_errors++;
            end
            if (got.relation !== want.relation) begin
                $error("relation expected %0d actual %0d", want.relation, got.relation);
                n_errors++;
            end
            if (got.error !== want.error) begin
                $error("error expected %0d actual %0d", want.error, got.error);
                n_errors++;
            end
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_item o_data;

    fraction_scoreboard sb = new();
    bit                 stim_done = 0;

    rational_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    // Receiver stall pattern: cycles through stall-free, light-stall and stall-heavy stretches.
    initial begin : receiver
        int phase;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase = (phase + 1) % 300;
            if (phase < 100) i_ready <= 1;
            else if (phase < 200) i_ready <= ($urandom_range(0, 3) != 0);
            else i_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_den();
        logic [15:0] v;
        v = pick_operand();
        if ($urandom_range(0, 15) != 0 && v == 0) v = 16'd1;
        return v;
    endfunction

    task automatic send(t_in_item it);
        i_data <= it;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic [2:0] c, logic [15:0] pa, logic [15:0] qa,
                               logic [15:0] pb, logic [15:0] qb);
        t_in_item it;
        it.command = c;
        it.num_a = pa;
        it.den_a = qa;
        it.num_b = pb;
        it.den_b = qb;
        send(it);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin : sender
        t_in_item it;
        int       burst, gap;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_fields(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_fields(CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_fields(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fields(CMD_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h0001);
        send_fields(CMD_DIV, 16'd3, 16'd4, 16'hfffe, 16'd5);
        send_fields(CMD_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
        send_fields(CMD_NEG, 16'h8000, 16'hffff, 16'd0, 16'd0);
        send_fields(CMD_NEG, 16'd5, 16'd0, 16'd1, 16'd1);
        send_fields(CMD_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
        send_fields(CMD_CMP, 16'd1, 16'd3, 16'd1, 16'd2);
        send_fields(CMD_CMP, 16'd1, 16'd0, 16'd1, 16'd2);
        send_fields(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd0);
        send_fields(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_fields(3'd6, 16'd1, 16'd2, 16'd1, 16'd3);
        send_fields(3'd7, 16'd0, 16'd0, 16'd0, 16'd0);
        send_fields(CMD_SUB, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_fields(CMD_DIV, 16'h8000, 16'h0001, 16'h0001, 16'h8000);

        drain();

        for (int k = 0; k < 400; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && k < 400; j++, k++) begin
                it.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                          : 3'($urandom_range(0, 5));
                it.num_a = pick_operand();
                it.den_a = pick_den();
                it.num_b = pick_operand();
                it.den_b = pick_den();
                send(it);
            end
            if (k == 200) begin
                drain();
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                i_valid <= 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 0;
        stim_done = 1;
    end

    initial begin : finisher
        wait (stim_done);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (sb.n_errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
